[rtl/core/cvis_pkg.sv]
// Shared types, codes and defaults for the credit-based VC injection scheduler.
// No dependencies; the scheduler and the checker refer to it by scoped names.
package cvis_pkg;

  localparam int NUM_VCS_DEF     = 4;
  localparam int QUEUE_DEPTH_DEF = 8;
  localparam int FLIT_WIDTH_DEF  = 64;

  localparam int PAYLOAD_W = 64;
  localparam int CREDIT_W  = 4;
  localparam int APB_AW    = 2;
  localparam int APB_DW    = 32;

  localparam logic [CREDIT_W-1:0] CREDIT_MAX       = 4'd15;
  localparam logic [CREDIT_W-1:0] CREDIT_LIMIT_RST = 4'd1;

  localparam logic [APB_AW-1:0] REG_CREDIT_LIMIT = 2'd0;

  localparam logic [1:0] FUNC_TICK   = 2'd0;
  localparam logic [1:0] FUNC_PUSH   = 2'd1;
  localparam logic [1:0] FUNC_CREDIT = 2'd2;
  localparam logic [1:0] FUNC_RSVD   = 2'd3;

  localparam logic [1:0] KIND_HEAD   = 2'd0;
  localparam logic [1:0] KIND_BODY   = 2'd1;
  localparam logic [1:0] KIND_TAIL   = 2'd2;
  localparam logic [1:0] KIND_SINGLE = 2'd3;

  localparam logic [1:0] ERR_NONE       = 2'd0;
  localparam logic [1:0] ERR_QUEUE_FULL = 2'd1;
  localparam logic [1:0] ERR_CREDIT_OVF = 2'd2;

  typedef struct packed {
    logic                 sent;
    logic [1:0]           vc;
    logic [1:0]           kind;
    logic [PAYLOAD_W-1:0] payload;
    logic                 packet_sent;
    logic [1:0]           error;
  } result_t;

  function automatic logic is_head_kind(input logic [1:0] k);
    return (k == KIND_HEAD) || (k == KIND_SINGLE);
  endfunction

  function automatic logic is_last_kind(input logic [1:0] k);
    return (k == KIND_TAIL) || (k == KIND_SINGLE);
  endfunction

endpackage

[rtl/core/cvis_ram.sv]
// Generic single-clock RAM: one write port, one read port, registered read data.
// No package dependencies.
module cvis_ram #(
  parameter int WIDTH = 66,
  parameter int DEPTH = 32,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[rtl/core/credit_vc_injection_scheduler.sv]
// Push, credit return, unknown code and an idle tick register their result at the input
// transfer; a granting tick reads the flit store in ST_FETCH first. Throughput: one item per
// cycle for push and credit return while the result queue has room; a granting tick holds the
// input through ST_FETCH, and ST_FRONT too when the queue still holds flits (one flit-store
// read port: flit, then the new front kind). Synchronous reset clears queues, requests and
// grant pointer, sets credit_limit and every credit count to 1; the flit store is not cleared.
module credit_vc_injection_scheduler #(
  parameter int NUM_VCS     = cvis_pkg::NUM_VCS_DEF,
  parameter int QUEUE_DEPTH = cvis_pkg::QUEUE_DEPTH_DEF,
  parameter int FLIT_WIDTH  = cvis_pkg::FLIT_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,

  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [cvis_pkg::APB_AW-1:0]   paddr,
  input  logic [cvis_pkg::APB_DW-1:0]   pwdata,
  output logic [cvis_pkg::APB_DW-1:0]   prdata,
  output logic                          pready,

  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    in_func,
  input  logic [1:0]                    in_vc,
  input  logic [1:0]                    in_flit_kind,
  input  logic [cvis_pkg::PAYLOAD_W-1:0] in_flit_payload,

  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_sent,
  output logic [1:0]                    out_sent_vc,
  output logic [1:0]                    out_sent_kind,
  output logic [cvis_pkg::PAYLOAD_W-1:0] out_sent_payload,
  output logic                          out_packet_sent,
  output logic [1:0]                    out_error
);

  localparam int VCW    = (NUM_VCS > 1) ? $clog2(NUM_VCS) : 1;
  localparam int QW     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);
  localparam int DEPTH  = NUM_VCS * QUEUE_DEPTH;
  localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int EW     = FLIT_WIDTH + 2;
  localparam int CW     = cvis_pkg::CREDIT_W;

  typedef enum logic [1:0] {ST_IDLE, ST_FETCH, ST_FRONT} state_t;

  state_t                 state_r, state_nxt;
  logic [CW-1:0]          limit_r, limit_nxt;
  logic [CW-1:0]          credit_r   [NUM_VCS];
  logic [CW-1:0]          credit_nxt [NUM_VCS];
  logic [QW-1:0]          rd_ptr_r   [NUM_VCS];
  logic [QW-1:0]          rd_ptr_nxt [NUM_VCS];
  logic [QW-1:0]          wr_ptr_r   [NUM_VCS];
  logic [QW-1:0]          wr_ptr_nxt [NUM_VCS];
  logic [FILL_W-1:0]      fill_r     [NUM_VCS];
  logic [FILL_W-1:0]      fill_nxt   [NUM_VCS];
  logic [1:0]             front_kind_r   [NUM_VCS];
  logic [1:0]             front_kind_nxt [NUM_VCS];
  logic [NUM_VCS-1:0]     ready_r, ready_nxt;
  logic [NUM_VCS-1:0]     pending_r, pending_nxt;
  logic [VCW-1:0]         last_grant_r, last_grant_nxt;
  logic [VCW-1:0]         gnt_ch_r, gnt_ch_nxt;

  cvis_pkg::result_t      head_r, head_nxt, skid_r, skid_nxt, res_new;
  logic [1:0]             cnt_r, cnt_nxt;
  logic                   res_push, res_pop;

  logic                   ram_we, ram_re;
  logic [AW-1:0]          ram_wa, ram_ra;
  logic [EW-1:0]          ram_wd, ram_rd;

  logic                   in_xfer, vc_ok, cfg_wr;
  logic [VCW-1:0]         vc_idx;
  logic [NUM_VCS-1:0]     req_set, pend_now, cand;
  logic                   found;
  logic [VCW-1:0]         win;

  function automatic logic [AW-1:0] ent_addr(input logic [VCW-1:0] ch,
                                             input logic [QW-1:0]  p);
    return AW'(ch) * AW'(QUEUE_DEPTH) + AW'(p);
  endfunction

  function automatic logic [QW-1:0] next_slot(input logic [QW-1:0] p);
    return (p == QW'(QUEUE_DEPTH - 1)) ? '0 : p + QW'(1);
  endfunction

  cvis_ram #(.WIDTH(EW), .DEPTH(DEPTH), .AW(AW)) u_flit_store (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_wa),
    .wr_data (ram_wd),
    .rd_en   (ram_re),
    .rd_addr (ram_ra),
    .rd_data (ram_rd)
  );

  assign pready   = 1'b1;
  assign prdata   = cvis_pkg::APB_DW'(limit_r);
  assign cfg_wr   = psel && penable && pwrite &&
                    (2'(paddr >> 2) == cvis_pkg::REG_CREDIT_LIMIT);

  assign in_stall = (state_r != ST_IDLE) || (cnt_r == 2'd2);
  assign in_xfer  = in_valid && !in_stall;
  assign vc_ok    = 32'(in_vc) < NUM_VCS;
  assign vc_idx   = VCW'(in_vc);

  assign out_valid        = (cnt_r != 2'd0);
  assign out_sent         = head_r.sent;
  assign out_sent_vc      = head_r.vc;
  assign out_sent_kind    = head_r.kind;
  assign out_sent_payload = head_r.payload;
  assign out_packet_sent  = head_r.packet_sent;
  assign out_error        = head_r.error;
  assign res_pop          = out_valid && !out_stall;

  always_comb begin
    int idx;
    for (int i = 0; i < NUM_VCS; i++) begin
      req_set[i] = ready_r[i] && (fill_r[i] != '0) && (credit_r[i] != '0) &&
                   (!cvis_pkg::is_head_kind(front_kind_r[i]) || (credit_r[i] == limit_r));
    end
    pend_now = pending_r | req_set;
    for (int i = 0; i < NUM_VCS; i++) begin
      cand[i] = pend_now[i] && (fill_r[i] != '0);
    end
    found = 1'b0;
    win   = '0;
    for (int n = 1; n <= NUM_VCS; n++) begin
      idx = int'(last_grant_r) + n;
      if (idx >= NUM_VCS) begin
        idx = idx - NUM_VCS;
      end
      if (!found && cand[idx]) begin
        found = 1'b1;
        win   = VCW'(idx);
      end
    end
  end

  always_comb begin
    state_nxt      = state_r;
    limit_nxt      = limit_r;
    credit_nxt     = credit_r;
    rd_ptr_nxt     = rd_ptr_r;
    wr_ptr_nxt     = wr_ptr_r;
    fill_nxt       = fill_r;
    front_kind_nxt = front_kind_r;
    ready_nxt      = ready_r;
    pending_nxt    = pending_r;
    last_grant_nxt = last_grant_r;
    gnt_ch_nxt     = gnt_ch_r;
    ram_we         = 1'b0;
    ram_wa         = '0;
    ram_wd         = '0;
    ram_re         = 1'b0;
    ram_ra         = '0;
    res_push       = 1'b0;
    res_new        = '0;

    if (cfg_wr) begin
      limit_nxt = pwdata[CW-1:0];
    end

    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          case (in_func)
            cvis_pkg::FUNC_TICK: begin
              pending_nxt = pend_now;
              if (found) begin
                pending_nxt[win]  = 1'b0;
                last_grant_nxt    = win;
                gnt_ch_nxt        = win;
                rd_ptr_nxt[win]   = next_slot(rd_ptr_r[win]);
                fill_nxt[win]     = fill_r[win] - FILL_W'(1);
                if (credit_r[win] != '0) begin
                  credit_nxt[win] = credit_r[win] - CW'(1);
                end
                if (cvis_pkg::is_last_kind(front_kind_r[win])) begin
                  ready_nxt[win] = 1'b0;
                end
                ram_re    = 1'b1;
                ram_ra    = ent_addr(win, rd_ptr_r[win]);
                state_nxt = ST_FETCH;
              end else begin
                res_push = 1'b1;
              end
            end
            cvis_pkg::FUNC_PUSH: begin
              res_push = 1'b1;
              if (vc_ok) begin
                if (fill_r[vc_idx] == FILL_W'(QUEUE_DEPTH)) begin
                  res_new.error = cvis_pkg::ERR_QUEUE_FULL;
                end else begin
                  ram_we             = 1'b1;
                  ram_wa             = ent_addr(vc_idx, wr_ptr_r[vc_idx]);
                  ram_wd             = {in_flit_kind, in_flit_payload[FLIT_WIDTH-1:0]};
                  wr_ptr_nxt[vc_idx] = next_slot(wr_ptr_r[vc_idx]);
                  fill_nxt[vc_idx]   = fill_r[vc_idx] + FILL_W'(1);
                  if (fill_r[vc_idx] == '0) begin
                    front_kind_nxt[vc_idx] = in_flit_kind;
                  end
                  if (cvis_pkg::is_last_kind(in_flit_kind)) begin
                    ready_nxt[vc_idx] = 1'b1;
                  end
                end
              end
            end
            cvis_pkg::FUNC_CREDIT: begin
              res_push = 1'b1;
              if (vc_ok) begin
                if ((credit_r[vc_idx] >= limit_r) ||
                    (credit_r[vc_idx] == cvis_pkg::CREDIT_MAX)) begin
                  res_new.error = cvis_pkg::ERR_CREDIT_OVF;
                end else begin
                  credit_nxt[vc_idx] = credit_r[vc_idx] + CW'(1);
                end
              end
            end
            default: begin
              res_push = 1'b1;
            end
          endcase
        end
      end
      ST_FETCH: begin
        res_push            = 1'b1;
        res_new.sent        = 1'b1;
        res_new.vc          = 2'(gnt_ch_r);
        res_new.kind        = ram_rd[EW-1:FLIT_WIDTH];
        res_new.payload     = cvis_pkg::PAYLOAD_W'(ram_rd[FLIT_WIDTH-1:0]);
        res_new.packet_sent = cvis_pkg::is_last_kind(ram_rd[EW-1:FLIT_WIDTH]);
        if (fill_r[gnt_ch_r] != '0) begin
          ram_re    = 1'b1;
          ram_ra    = ent_addr(gnt_ch_r, rd_ptr_r[gnt_ch_r]);
          state_nxt = ST_FRONT;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_FRONT: begin
        front_kind_nxt[gnt_ch_r] = ram_rd[EW-1:FLIT_WIDTH];
        state_nxt                = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    head_nxt = head_r;
    skid_nxt = skid_r;
    if (res_push && ((cnt_r == 2'd0) || ((cnt_r == 2'd1) && res_pop))) begin
      head_nxt = res_new;
    end else if (res_pop && (cnt_r == 2'd2)) begin
      head_nxt = skid_r;
    end
    if (res_push && (cnt_r == 2'd1) && !res_pop) begin
      skid_nxt = res_new;
    end
    cnt_nxt = cnt_r + 2'(res_push) - 2'(res_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      limit_r      <= cvis_pkg::CREDIT_LIMIT_RST;
      ready_r      <= '0;
      pending_r    <= '0;
      last_grant_r <= '0;
      cnt_r        <= '0;
      for (int i = 0; i < NUM_VCS; i++) begin
        credit_r[i] <= cvis_pkg::CREDIT_LIMIT_RST;
        rd_ptr_r[i] <= '0;
        wr_ptr_r[i] <= '0;
        fill_r[i]   <= '0;
      end
    end else begin
      state_r      <= state_nxt;
      limit_r      <= limit_nxt;
      ready_r      <= ready_nxt;
      pending_r    <= pending_nxt;
      last_grant_r <= last_grant_nxt;
      cnt_r        <= cnt_nxt;
      credit_r     <= credit_nxt;
      rd_ptr_r     <= rd_ptr_nxt;
      wr_ptr_r     <= wr_ptr_nxt;
      fill_r       <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    front_kind_r <= front_kind_nxt;
    gnt_ch_r     <= gnt_ch_nxt;
    head_r       <= head_nxt;
    skid_r       <= skid_nxt;
  end

endmodule

[rtl/core/cvis_checker.sv]
// Port-level assertions for the VC injection scheduler, bound to its top level.
// Depends on cvis_pkg for flit kind and error codes.
module cvis_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           psel,
  input logic                           penable,
  input logic                           pwrite,
  input logic [cvis_pkg::APB_AW-1:0]    paddr,
  input logic [cvis_pkg::APB_DW-1:0]    pwdata,
  input logic [cvis_pkg::APB_DW-1:0]    prdata,
  input logic                           pready,
  input logic                           in_valid,
  input logic                           in_stall,
  input logic [1:0]                     in_func,
  input logic [1:0]                     in_vc,
  input logic [1:0]                     in_flit_kind,
  input logic [cvis_pkg::PAYLOAD_W-1:0] in_flit_payload,
  input logic                           out_valid,
  input logic                           out_stall,
  input logic                           out_sent,
  input logic [1:0]                     out_sent_vc,
  input logic [1:0]                     out_sent_kind,
  input logic [cvis_pkg::PAYLOAD_W-1:0] out_sent_payload,
  input logic                           out_packet_sent,
  input logic [1:0]                     out_error
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_sent) && $stable(out_sent_vc) &&
      $stable(out_sent_kind) && $stable(out_sent_payload) && $stable(out_error))
    else $error("stalled result changed");

  a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_sent |-> out_sent_vc == 2'd0 && out_sent_kind == 2'd0 &&
      out_sent_payload == '0 && !out_packet_sent)
    else $error("no-send result carries flit fields");

  a_packet_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_sent |-> out_packet_sent ==
      (out_sent_kind == cvis_pkg::KIND_TAIL || out_sent_kind == cvis_pkg::KIND_SINGLE))
    else $error("packet_sent disagrees with sent flit kind");

  a_send_no_error: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_sent |-> out_error == cvis_pkg::ERR_NONE)
    else $error("sent flit flagged with an error");

  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    psel && penable |-> pready)
    else $error("config access not completed");

endmodule

bind credit_vc_injection_scheduler cvis_checker u_cvis_checker (.*);
